FILE: hdl/assert_macros.svh
// assertion macros used by the selector rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: hdl/usbpd_pkg.sv
// types, codes and constants of the source capabilities selector
// no dependencies
package usbpd_pkg;

    localparam int CODE_W  = 10;
    localparam int MA_W    = 14;
    localparam int MV_W    = 16;
    localparam int POWER_W = 19;
    localparam int CNT_W   = 3;
    localparam int SINK_W  = 20;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_COUNT   = 3'b010,
        PH_OBJECTS = 3'b100
    } phase_t;

    localparam logic [1:0] ACT_HEADER = 2'd0;
    localparam logic [1:0] ACT_COUNT  = 2'd1;
    localparam logic [1:0] ACT_OBJECT = 2'd2;

    localparam logic [1:0] ST_CHOSEN   = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [CIDX_W-1:0] REG_MIN_CURRENT = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_VOLTAGE = 3'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_VOLTAGE = 3'd2;
    localparam logic [CIDX_W-1:0] REG_REV3_MASK   = 3'd3;

    localparam logic [MA_W-1:0] RST_MIN_CURRENT = 14'd500;
    localparam logic [MV_W-1:0] RST_MIN_VOLTAGE = 16'd5000;
    localparam logic [MV_W-1:0] RST_MAX_VOLTAGE = 16'd20000;

    localparam logic [4:0]      SRC_CAP_TYPE = 5'h01;
    localparam logic [MA_W-1:0] MA_PER_CODE  = 14'd10;
    localparam logic [MV_W-1:0] MV_PER_CODE  = 16'd50;

    typedef struct packed {
        logic [MA_W-1:0] min_current_ma;
        logic [MV_W-1:0] min_voltage_mv;
        logic [MV_W-1:0] max_voltage_mv;
        logic            rev3_type_mask;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]  ccode;
        logic [CODE_W-1:0]  vcode;
        logic [MA_W-1:0]    cur_ma;
        logic [MV_W-1:0]    volt_mv;
        logic [POWER_W-1:0] power;
        logic               take;
    } pdo_eval_t;

endpackage

FILE: hdl/usbpd_cfg_regs.sv
// configuration registers of the source capabilities selector
// depends on usbpd_pkg
module usbpd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [usbpd_pkg::CIDX_W-1:0]   wr_index,
    input  logic [usbpd_pkg::CDATA_W-1:0]  wr_data,
    output usbpd_pkg::cfg_t                cfg
);

    usbpd_pkg::cfg_t cfg_reg;
    usbpd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                usbpd_pkg::REG_MIN_CURRENT:
                    cfg_next.min_current_ma = wr_data[usbpd_pkg::MA_W-1:0];
                usbpd_pkg::REG_MIN_VOLTAGE:
                    cfg_next.min_voltage_mv = wr_data;
                usbpd_pkg::REG_MAX_VOLTAGE:
                    cfg_next.max_voltage_mv = wr_data;
                usbpd_pkg::REG_REV3_MASK:
                    cfg_next.rev3_type_mask = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_current_ma <= usbpd_pkg::RST_MIN_CURRENT;
            cfg_reg.min_voltage_mv <= usbpd_pkg::RST_MIN_VOLTAGE;
            cfg_reg.max_voltage_mv <= usbpd_pkg::RST_MAX_VOLTAGE;
            cfg_reg.rev3_type_mask <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/usbpd_pdo_eval.sv
// decode of one source pdo: current, voltage, power and the limit check
// depends on usbpd_pkg
module usbpd_pdo_eval (
    input  logic [31:0]                     pdo_word,
    input  usbpd_pkg::cfg_t                 cfg,
    input  logic [usbpd_pkg::POWER_W-1:0]   best_power,
    output usbpd_pkg::pdo_eval_t            res
);

    logic [usbpd_pkg::CODE_W-1:0]  ccode;
    logic [usbpd_pkg::CODE_W-1:0]  vcode;
    logic [usbpd_pkg::MA_W-1:0]    cur_ma;
    logic [usbpd_pkg::MV_W-1:0]    volt_mv;
    logic [2*usbpd_pkg::CODE_W-1:0] prod;
    logic                          is_fixed;

    assign ccode   = pdo_word[9:0];
    assign vcode   = pdo_word[19:10];
    assign is_fixed = (pdo_word[31:30] == 2'b00);
    assign cur_ma  = {4'b0, ccode} * usbpd_pkg::MA_PER_CODE;
    assign volt_mv = {6'b0, vcode} * usbpd_pkg::MV_PER_CODE;

    // mA * mV / 1000 reduces to ccode * vcode / 2
    assign prod = {10'b0, ccode} * {10'b0, vcode};

    always_comb begin
        res.ccode   = ccode;
        res.vcode   = vcode;
        res.cur_ma  = cur_ma;
        res.volt_mv = volt_mv;
        res.power   = prod[2*usbpd_pkg::CODE_W-1:1];
        res.take    = is_fixed
                   && (cur_ma >= cfg.min_current_ma)
                   && (volt_mv >= cfg.min_voltage_mv)
                   && (volt_mv <= cfg.max_voltage_mv)
                   && (prod[2*usbpd_pkg::CODE_W-1:1] > best_power);
    end

endmodule

FILE: hdl/usb_pd_source_cap_selector.sv
// USB PD source capabilities selector. Follows a receive sequence of
// header, byte count and data object transactions, keeps the fixed PDO of
// highest power inside the current and voltage limits (first one wins a
// tie) and emits one result after the last object, or a mismatch status
// when the byte count disagrees with the header. One transaction is taken
// every clock; a transaction is held in the input register, is evaluated
// with a single 10x10 multiply and compare, and any result it gives is
// written into the output register. Input stalls only while the output
// register holds a result that has not been taken.
// depends on usbpd_pkg, usbpd_cfg_regs, usbpd_pdo_eval, assert_macros.svh
`include "assert_macros.svh"

module usb_pd_source_cap_selector (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [usbpd_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [usbpd_pkg::CDATA_W-1:0]      cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [31:0]                        s_data_word,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [usbpd_pkg::SINK_W-1:0]       m_sink_pdo_word,
    output logic [usbpd_pkg::MA_W-1:0]         m_chosen_current_ma,
    output logic [usbpd_pkg::MV_W-1:0]         m_chosen_voltage_mv,
    output logic [usbpd_pkg::POWER_W-1:0]      m_chosen_power_mw
);

    usbpd_pkg::cfg_t      cfg;
    usbpd_pkg::pdo_eval_t ev;

    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [31:0] in_word_reg;
    logic        proc_fire;

    usbpd_pkg::phase_t                  phase_reg, phase_next;
    logic [usbpd_pkg::CNT_W-1:0]        expected_reg, expected_next;
    logic [usbpd_pkg::CNT_W-1:0]        seen_reg, seen_next;
    logic [usbpd_pkg::CODE_W-1:0]       best_ccode_reg, best_ccode_next;
    logic [usbpd_pkg::CODE_W-1:0]       best_vcode_reg, best_vcode_next;
    logic [usbpd_pkg::MA_W-1:0]         best_ma_reg, best_ma_next;
    logic [usbpd_pkg::MV_W-1:0]         best_mv_reg, best_mv_next;
    logic [usbpd_pkg::POWER_W-1:0]      best_power_reg, best_power_next;
    logic                               found_reg, found_next;

    logic                               emit;
    logic [1:0]                         res_status;
    logic [usbpd_pkg::SINK_W-1:0]       res_sink;
    logic [usbpd_pkg::MA_W-1:0]         res_ma;
    logic [usbpd_pkg::MV_W-1:0]         res_mv;
    logic [usbpd_pkg::POWER_W-1:0]      res_power;

    logic                               m_valid_reg;
    logic [1:0]                         m_status_reg;
    logic [usbpd_pkg::SINK_W-1:0]       m_sink_reg;
    logic [usbpd_pkg::MA_W-1:0]         m_ma_reg;
    logic [usbpd_pkg::MV_W-1:0]         m_mv_reg;
    logic [usbpd_pkg::POWER_W-1:0]      m_power_reg;

    logic [4:0]                         hdr_type;
    logic [usbpd_pkg::CNT_W-1:0]        hdr_count;

    assign cfg_ready = 1'b1;

    usbpd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    usbpd_pdo_eval u_eval (
        .pdo_word   (in_word_reg),
        .cfg        (cfg),
        .best_power (best_power_reg),
        .res        (ev)
    );

    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_word_reg   <= s_data_word;
        end
    end

    assign hdr_type  = cfg.rev3_type_mask ? in_word_reg[4:0] : {1'b0, in_word_reg[3:0]};
    assign hdr_count = in_word_reg[14:12];

    always_comb begin
        phase_next      = phase_reg;
        expected_next   = expected_reg;
        seen_next       = seen_reg;
        best_ccode_next = best_ccode_reg;
        best_vcode_next = best_vcode_reg;
        best_ma_next    = best_ma_reg;
        best_mv_next    = best_mv_reg;
        best_power_next = best_power_reg;
        found_next      = found_reg;
        emit            = 1'b0;
        res_status      = usbpd_pkg::ST_CHOSEN;
        res_sink        = '0;
        res_ma          = '0;
        res_mv          = '0;
        res_power       = '0;

        unique case (in_action_reg)
            usbpd_pkg::ACT_HEADER: begin
                if (phase_reg == usbpd_pkg::PH_IDLE && hdr_count != '0
                        && hdr_type == usbpd_pkg::SRC_CAP_TYPE) begin
                    expected_next = hdr_count;
                    phase_next    = usbpd_pkg::PH_COUNT;
                end
            end
            usbpd_pkg::ACT_COUNT: begin
                if (phase_reg == usbpd_pkg::PH_COUNT) begin
                    if (in_word_reg[7:0] != {3'b000, expected_reg, 2'b00}) begin
                        phase_next = usbpd_pkg::PH_IDLE;
                        emit       = 1'b1;
                        res_status = usbpd_pkg::ST_MISMATCH;
                    end else begin
                        phase_next      = usbpd_pkg::PH_OBJECTS;
                        seen_next       = '0;
                        best_ccode_next = '0;
                        best_vcode_next = '0;
                        best_ma_next    = '0;
                        best_mv_next    = '0;
                        best_power_next = '0;
                        found_next      = 1'b0;
                    end
                end
            end
            usbpd_pkg::ACT_OBJECT: begin
                if (phase_reg == usbpd_pkg::PH_OBJECTS) begin
                    if (ev.take) begin
                        best_ccode_next = ev.ccode;
                        best_vcode_next = ev.vcode;
                        best_ma_next    = ev.cur_ma;
                        best_mv_next    = ev.volt_mv;
                        best_power_next = ev.power;
                        found_next      = 1'b1;
                    end
                    seen_next = seen_reg + 3'd1;
                    if (seen_next == expected_reg) begin
                        phase_next = usbpd_pkg::PH_IDLE;
                        emit       = 1'b1;
                        if (found_next) begin
                            res_status = usbpd_pkg::ST_CHOSEN;
                            res_sink   = {best_vcode_next, best_ccode_next};
                            res_ma     = best_ma_next;
                            res_mv     = best_mv_next;
                            res_power  = best_power_next;
                        end else begin
                            res_status = usbpd_pkg::ST_NONE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= usbpd_pkg::PH_IDLE;
            expected_reg   <= '0;
            seen_reg       <= '0;
            best_ccode_reg <= '0;
            best_vcode_reg <= '0;
            best_ma_reg    <= '0;
            best_mv_reg    <= '0;
            best_power_reg <= '0;
            found_reg      <= 1'b0;
        end else if (proc_fire) begin
            phase_reg      <= phase_next;
            expected_reg   <= expected_next;
            seen_reg       <= seen_next;
            best_ccode_reg <= best_ccode_next;
            best_vcode_reg <= best_vcode_next;
            best_ma_reg    <= best_ma_next;
            best_mv_reg    <= best_mv_next;
            best_power_reg <= best_power_next;
            found_reg      <= found_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            m_status_reg <= res_status;
            m_sink_reg   <= res_sink;
            m_ma_reg     <= res_ma;
            m_mv_reg     <= res_mv;
            m_power_reg  <= res_power;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_sink_pdo_word     = m_sink_reg;
    assign m_chosen_current_ma = m_ma_reg;
    assign m_chosen_voltage_mv = m_mv_reg;
    assign m_chosen_power_mw   = m_power_reg;

    `ASSERT_CLK(a_fail_fields_zero, aclk, aresetn,
        m_valid && m_status != usbpd_pkg::ST_CHOSEN |-> m_sink_pdo_word == '0 && m_chosen_power_mw == '0,
        "failure status with nonzero payload")
    `ASSERT_CLK(a_chosen_has_power, aclk, aresetn,
        m_valid && m_status == usbpd_pkg::ST_CHOSEN |-> m_chosen_power_mw != '0,
        "chosen pdo with zero power")
    `ASSERT_CLK(a_seen_below_expected, aclk, aresetn,
        phase_reg == usbpd_pkg::PH_OBJECTS |-> seen_reg < expected_reg,
        "object count ran past header count")
    `ASSERT_CLK(a_found_power, aclk, aresetn,
        found_reg == (best_power_reg != '0),
        "found flag disagrees with best power")
    `ASSERT_CLK(a_result_from_input, aclk, aresetn,
        m_valid && !$past(m_valid) |-> $past(in_valid_reg),
        "result appeared without a transaction in the input register")

endmodule

FILE: tb/sv/usb_pd_source_cap_selector_test.sv
// self-checking testbench for usb_pd_source_cap_selector: a scoreboard class
// predicts the pdo choice from the accepted transactions; depends on usbpd_pkg
// and the selector rtl
`timescale 1ns / 100ps

module usb_pd_source_cap_selector_test;
    import usbpd_pkg::*;

    localparam int          RESET_CYCLES    = 7;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          ITEMS_PER_PHASE = 240;
    localparam int          IDLE_PERCENT    = 34;
    localparam int unsigned MW_SCALE        = 1000;
    localparam logic [1:0]  ACT_RESERVED    = 2'd3;
    localparam logic [1:0]  PDO_FIXED       = 2'b00;

    typedef struct packed {
        logic [1:0]         status;
        logic [SINK_W-1:0]  sink_pdo_word;
        logic [MA_W-1:0]    cur_ma;
        logic [MV_W-1:0]    volt_mv;
        logic [POWER_W-1:0] power_mw;
    } pd_result_t;

    class pdo_choice_tracker;
        cfg_t               limits;
        phase_t             msg_phase;
        logic [CNT_W-1:0]   objs_expected;
        logic [CNT_W-1:0]   objs_seen;
        logic [CODE_W-1:0]  best_ccode;
        logic [CODE_W-1:0]  best_vcode;
        logic [POWER_W-1:0] best_power;
        bit                 found;
        pd_result_t         pending_choices[$];
        int                 fails;

        function new();
            limits.min_current_ma = RST_MIN_CURRENT;
            limits.min_voltage_mv = RST_MIN_VOLTAGE;
            limits.max_voltage_mv = RST_MAX_VOLTAGE;
            limits.rev3_type_mask = 1'b0;
            msg_phase = PH_IDLE;
            objs_expected = '0;
            fails = 0;
            clear_best();
        endfunction

        function void clear_best();
            objs_seen = '0;
            best_ccode = '0;
            best_vcode = '0;
            best_power = '0;
            found = 1'b0;
        endfunction

        function void write_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                REG_MIN_CURRENT: limits.min_current_ma = data[MA_W-1:0];
                REG_MIN_VOLTAGE: limits.min_voltage_mv = data;
                REG_MAX_VOLTAGE: limits.max_voltage_mv = data;
                REG_REV3_MASK:   limits.rev3_type_mask = data[0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] st, logic [CODE_W-1:0] cc,
                                  logic [CODE_W-1:0] vc, logic [POWER_W-1:0] pw);
            pd_result_t r;
            r.status        = st;
            r.sink_pdo_word = {vc, cc};
            r.cur_ma        = cc * MA_PER_CODE;
            r.volt_mv       = vc * MV_PER_CODE;
            r.power_mw      = pw;
            pending_choices.push_back(r);
        endfunction

        function void take_transaction(logic [1:0] act, logic [31:0] word);
            logic [4:0]        mtype;
            logic [CNT_W-1:0]  cnt;
            logic [CODE_W-1:0] cc;
            logic [CODE_W-1:0] vc;
            int unsigned       cur;
            int unsigned       volt;
            int unsigned       pw;
            case (act)
                ACT_HEADER: begin
                    mtype = limits.rev3_type_mask ? word[4:0] : {1'b0, word[3:0]};
                    cnt = word[14:12];
                    if (msg_phase == PH_IDLE && cnt != 0 && mtype == SRC_CAP_TYPE) begin
                        objs_expected = cnt;
                        msg_phase = PH_COUNT;
                    end
                end
                ACT_COUNT: begin
                    if (msg_phase == PH_COUNT) begin
                        if (word[7:0] != {3'b000, objs_expected, 2'b00}) begin
                            msg_phase = PH_IDLE;
                            push_result(ST_MISMATCH, '0, '0, '0);
                        end else begin
                            clear_best();
                            msg_phase = PH_OBJECTS;
                        end
                    end
                end
                ACT_OBJECT: begin
                    if (msg_phase == PH_OBJECTS) begin
                        cc = word[9:0];
                        vc = word[19:10];
                        cur = cc * MA_PER_CODE;
                        volt = vc * MV_PER_CODE;
                        pw = cur * volt / MW_SCALE;
                        if (word[31:30] == PDO_FIXED && cur >= limits.min_current_ma &&
                            volt >= limits.min_voltage_mv &&
                            volt <= limits.max_voltage_mv && pw > best_power) begin
                            best_ccode = cc;
                            best_vcode = vc;
                            best_power = pw[POWER_W-1:0];
                            found = 1'b1;
                        end
                        objs_seen = objs_seen + 1'b1;
                        if (objs_seen == objs_expected) begin
                            msg_phase = PH_IDLE;
                            if (found)
                                push_result(ST_CHOSEN, best_ccode, best_vcode, best_power);
                            else
                                push_result(ST_NONE, '0, '0, '0);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_choice(pd_result_t got);
            pd_result_t want;
            if (pending_choices.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d",
                         $time, got.status);
                fails++;
                return;
            end
            want = pending_choices.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("sink_pdo_word", want.sink_pdo_word, got.sink_pdo_word);
            compare_field("chosen_current_ma", want.cur_ma, got.cur_ma);
            compare_field("chosen_voltage_mv", want.volt_mv, got.volt_mv);
            compare_field("chosen_power_mw", want.power_mw, got.power_mw);
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn     = 1'b0;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CIDX_W-1:0]       cfg_index   = '0;
    logic [CDATA_W-1:0]      cfg_data    = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_action    = ACT_HEADER;
    logic [31:0]             s_data_word = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [1:0]              m_status;
    logic [SINK_W-1:0]       m_sink_pdo_word;
    logic [MA_W-1:0]         m_chosen_current_ma;
    logic [MV_W-1:0]         m_chosen_voltage_mv;
    logic [POWER_W-1:0]      m_chosen_power_mw;

    pdo_choice_tracker tracker;
    pd_result_t        seen_result;
    bit                calm        = 1'b0;
    int                items_sent  = 0;
    int                cycle_count = 0;

    usb_pd_source_cap_selector i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_data_word         (s_data_word),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sink_pdo_word     (m_sink_pdo_word),
        .m_chosen_current_ma (m_chosen_current_ma),
        .m_chosen_voltage_mv (m_chosen_voltage_mv),
        .m_chosen_power_mw   (m_chosen_power_mw)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.write_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                tracker.take_transaction(s_action, s_data_word);
            if (m_valid && m_ready) begin
                seen_result.status        = m_status;
                seen_result.sink_pdo_word = m_sink_pdo_word;
                seen_result.cur_ma        = m_chosen_current_ma;
                seen_result.volt_mv       = m_chosen_voltage_mv;
                seen_result.power_mw      = m_chosen_power_mw;
                tracker.check_choice(seen_result);
            end
        end
    end

    function automatic logic [31:0] fixed_pdo(logic [CODE_W-1:0] vc, logic [CODE_W-1:0] cc);
        return {12'h000, vc, cc};
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [31:0] word);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_word <= word;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_choices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CDATA_W-1:0] cur, input logic [CDATA_W-1:0] vmin,
                                  input logic [CDATA_W-1:0] vmax, input logic [CDATA_W-1:0] mask,
                                  input bit stray);
        settle();
        write_reg(REG_MIN_CURRENT, cur);
        write_reg(REG_MIN_VOLTAGE, vmin);
        write_reg(REG_MAX_VOLTAGE, vmax);
        write_reg(REG_REV3_MASK, mask);
        if (stray)
            write_reg(CIDX_W'(REG_REV3_MASK + 1 + $urandom_range(0, 3)), CDATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_pdo();
        logic [31:0]       w;
        logic [1:0]        kind;
        logic [CODE_W-1:0] vc;
        logic [CODE_W-1:0] cc;
        w = $urandom;
        kind = ($urandom_range(0, 99) < 80) ? PDO_FIXED : w[31:30];
        vc = ($urandom_range(0, 3) == 0) ? w[19:10] : CODE_W'($urandom_range(80, 420));
        cc = ($urandom_range(0, 3) == 0) ? w[9:0] : CODE_W'($urandom_range(0, 520));
        if ($urandom_range(0, 19) == 0)
            vc = '0;
        if ($urandom_range(0, 19) == 0)
            cc = '0;
        return {kind, w[29:20], vc, cc};
    endfunction

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic random_message();
        logic [31:0] hw;
        logic [31:0] cw;
        logic [31:0] ow;
        logic [31:0] prev;
        int          n;
        hw = $urandom;
        if ($urandom_range(0, 99) < 75)
            hw[3:0] = SRC_CAP_TYPE[3:0];
        if ($urandom_range(0, 99) < 85)
            hw[14:12] = CNT_W'($urandom_range(1, 7));
        send_item(ACT_HEADER, hw);
        cw = $urandom;
        if ($urandom_range(0, 99) < 85)
            cw[7:0] = {3'b000, hw[14:12], 2'b00};
        send_item(ACT_COUNT, cw);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : int'(hw[14:12]);
        prev = '0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            // swapping the two codes keeps the power, which makes a tie
            if (k > 0 && $urandom_range(0, 9) == 0)
                ow = {PDO_FIXED, prev[29:20], prev[9:0], prev[19:10]};
            else
                ow = pick_pdo();
            send_item(ACT_OBJECT, ow);
            prev = ow;
        end
    endtask

    task automatic random_traffic(input int quota);
        int stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                random_message();
        end
    endtask

    initial begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits, four-bit type field
        send_item(ACT_HEADER, 32'h0000_1001);
        send_item(ACT_COUNT, 32'd4);
        send_item(ACT_OBJECT, fixed_pdo(10'd100, 10'd300));
        send_item(ACT_HEADER, 32'hFFFF_1011);
        send_item(ACT_COUNT, 32'hFFFF_FF04);
        send_item(ACT_OBJECT, 32'hFFFF_FFFF);
        send_item(ACT_HEADER, 32'h0000_0001);
        send_item(ACT_COUNT, 32'd0);
        send_item(ACT_OBJECT, fixed_pdo(10'd100, 10'd300));
        send_item(ACT_RESERVED, 32'h0000_1001);
        send_item(ACT_HEADER, 32'h0000_1002);
        send_item(ACT_HEADER, 32'h0000_7001);
        send_item(ACT_COUNT, 32'd27);
        send_item(ACT_HEADER, 32'h0000_3001);
        send_item(ACT_HEADER, 32'h0000_1001);
        send_item(ACT_COUNT, 32'd12);
        send_item(ACT_COUNT, 32'd12);
        send_item(ACT_OBJECT, fixed_pdo(10'd180, 10'd300));
        send_item(ACT_OBJECT, fixed_pdo(10'd300, 10'd180));
        send_item(ACT_OBJECT, fixed_pdo(10'd400, 10'd50));
        send_item(ACT_OBJECT, 32'h0000_0000);
        send_item(ACT_HEADER, 32'h0000_F001);
        send_item(ACT_COUNT, 32'd28);
        send_item(ACT_OBJECT, 32'h0000_0000);
        send_item(ACT_OBJECT, fixed_pdo(10'd401, 10'd1023));
        send_item(ACT_OBJECT, fixed_pdo(10'd99, 10'd1023));
        send_item(ACT_OBJECT, fixed_pdo(10'd400, 10'd49));
        send_item(ACT_OBJECT, fixed_pdo(10'd100, 10'd50));
        send_item(ACT_OBJECT, fixed_pdo(10'd400, 10'd1023));
        send_item(ACT_OBJECT, 32'hC00F_FFFF);
        random_traffic(ITEMS_PER_PHASE);

        // no lower limits, widest voltage window, five-bit type field
        apply_settings(16'd0, 16'd0, 16'hFFFF, 16'd1, 1'b0);
        send_item(ACT_HEADER, 32'h0000_1011);
        send_item(ACT_HEADER, 32'h0000_2001);
        send_item(ACT_COUNT, 32'd8);
        send_item(ACT_OBJECT, fixed_pdo(10'd100, 10'd0));
        send_item(ACT_OBJECT, fixed_pdo(10'd1, 10'd1));
        send_item(ACT_HEADER, 32'h0000_1001);
        send_item(ACT_COUNT, 32'd4);
        send_item(ACT_OBJECT, fixed_pdo(10'd1, 10'd2));
        random_traffic(ITEMS_PER_PHASE);

        apply_settings(16'd10230, 16'd0, 16'd51150, 16'd0, 1'b0);
        random_traffic(ITEMS_PER_PHASE);

        apply_settings(16'd3000, 16'd9000, 16'd15000, 16'd1, 1'b1);
        calm = 1'b1;
        random_traffic(ITEMS_PER_PHASE);
        calm = 1'b0;

        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        random_traffic(ITEMS_PER_PHASE);

        apply_settings(16'hFFFF, 16'd51150, 16'd0, 16'hFFFE, 1'b1);
        random_traffic(ITEMS_PER_PHASE);

        apply_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 9000)),
                       16'($urandom_range(9000, 51150)), 16'($urandom), 1'b1);
        random_traffic(ITEMS_PER_PHASE);

        apply_settings(16'd500, 16'd5000, 16'd20000, 16'd0, 1'b1);
        random_traffic(ITEMS_PER_PHASE);

        settle();
        if (tracker.fails == 0 && tracker.pending_choices.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/usbpd_pkg.sv
hdl/usbpd_cfg_regs.sv
hdl/usbpd_pdo_eval.sv
hdl/usb_pd_source_cap_selector.sv
tb/sv/usb_pd_source_cap_selector_test.sv
